>>> sv/qau_pkg.sv
// Shared types, operation codes and helper functions of the quaternion arithmetic unit.
package qau_pkg;

  typedef enum logic [2:0] {
    OP_MULT  = 3'd0,
    OP_DOT   = 3'd1,
    OP_ADD   = 3'd2,
    OP_SCALE = 3'd3,
    OP_NORM  = 3'd4,
    OP_CONJ  = 3'd5,
    OP_W2B   = 3'd6,
    OP_B2W   = 3'd7
  } op_t;

  // Four Q-format components, w in the lowest 32 bits.
  typedef logic [3:0][31:0] quat_t;

  // Results that are ready at the front of the pipeline and ride along to the merge.
  typedef struct packed {
    op_t        op;
    quat_t      res;
    logic       sat;
    logic       zn;
    logic [3:0] neg;
  } side_t;

  localparam logic signed [65:0] CL_MAX = 66'sd2147483647;
  localparam logic signed [65:0] CL_MIN = -66'sd2147483648;

  // Sign pattern of the Hamilton product: bit k is set where term k is subtracted.
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  // Returns {clamped, value}.
  function automatic logic [32:0] clamp32(input logic signed [65:0] v);
    logic [32:0] o;
    if (v > CL_MAX) begin
      o = {1'b1, 32'h7FFF_FFFF};
    end else if (v < CL_MIN) begin
      o = {1'b1, 32'h8000_0000};
    end else begin
      o = {1'b0, v[31:0]};
    end
    return o;
  endfunction

  // Term k of output lane l multiplies x[k] by y[l ^ k].
  function automatic quat_t ham_perm(input quat_t y, input logic [1:0] lane);
    quat_t r;
    for (int k = 0; k < 4; k++) begin
      r[k] = y[lane ^ k[1:0]];
    end
    return r;
  endfunction

endpackage

>>> sv/qau_delay.sv
// Enabled shift line that carries payload alongside the long arithmetic paths.
module qau_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

>>> sv/qau_prod_lane.sv
// One output component: four signed products, truncated, signed sum and clamp.
module qau_prod_lane
  import qau_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        en,
  input  quat_t       x,
  input  quat_t       y,
  input  logic [3:0]  neg,
  output logic [31:0] r,
  output logic        sat
);

  logic signed [63:0] p_r [4];
  logic [3:0]         neg_r;
  logic [31:0]        r_r;
  logic               sat_r;
  logic [32:0]        cl;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p_r[k] <= $signed(x[k]) * $signed(y[k]);
      end
      neg_r <= neg;
    end
  end

  always_comb begin
    logic signed [65:0] ext;
    logic signed [65:0] sum;
    sum = '0;
    for (int k = 0; k < 4; k++) begin
      ext = {{2{p_r[k][63]}}, p_r[k]};
      ext = ext >>> FRAC_BITS;
      sum = neg_r[k] ? (sum - ext) : (sum + ext);
    end
    cl = clamp32(sum);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= cl[31:0];
      sat_r <= cl[32];
    end
  end

  assign r   = r_r;
  assign sat = sat_r;

endmodule

>>> sv/qau_isqrt.sv
// Pipelined floor square root of a 66-bit value, one result bit per stage.
module qau_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [65:0] s,
  output logic [32:0] root
);

  logic [65:0] s_r    [33];
  logic [33:0] rem_r  [33];
  logic [32:0] root_r [33];

  for (genvar j = 0; j < 33; j++) begin : g_st
    localparam int P = 32 - j;
    logic [65:0] s_in;
    logic [33:0] rem_in;
    logic [32:0] root_in;
    logic [35:0] rsh;
    logic [35:0] tst;
    logic        ge;

    if (j == 0) begin : g_first
      assign s_in    = s;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign s_in    = s_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    assign rsh = {rem_in, s_in[2*P+1 -: 2]};
    assign tst = {1'b0, root_in, 2'b01};
    assign ge  = (rsh >= tst);

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[j]    <= s_in;
        rem_r[j]  <= ge ? 34'(rsh - tst) : rsh[33:0];
        root_r[j] <= {root_in[31:0], ge};
      end
    end
  end

  assign root = root_r[32];

endmodule

>>> sv/qau_div_lane.sv
// Pipelined restoring divider: (m << FRAC_BITS) / d, one quotient bit per stage.
module qau_div_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        m,
  input  logic [32:0]        d,
  output logic [FRAC_BITS:0] q
);

  localparam int NST = FRAC_BITS + 1;
  localparam int W   = FRAC_BITS + 34;

  logic [W-1:0]       r_r [NST];
  logic [32:0]        d_r [NST];
  logic [FRAC_BITS:0] q_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam int J = FRAC_BITS - k;
    logic [W-1:0]       r_in;
    logic [32:0]        d_in;
    logic [FRAC_BITS:0] q_in;
    logic [W-1:0]       dsh;
    logic               ge;
    logic [FRAC_BITS:0] q_nxt;

    if (k == 0) begin : g_first
      assign r_in = {{(W-32){1'b0}}, m} << FRAC_BITS;
      assign d_in = d;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_r[k-1];
      assign d_in = d_r[k-1];
      assign q_in = q_r[k-1];
    end

    assign dsh = {{(W-33){1'b0}}, d_in} << J;
    assign ge  = (r_in >= dsh);

    always_comb begin
      q_nxt    = q_in;
      q_nxt[J] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k] <= ge ? (r_in - dsh) : r_in;
        d_r[k] <= d_in;
        q_r[k] <= q_nxt;
      end
    end
  end

  assign q = q_r[NST-1];

endmodule

>>> sv/quaternion_arithmetic_unit_top.sv
// Top level of the quaternion arithmetic unit: operand setup, product lanes, normalize path, merge.
// The unit is a single pipeline that accepts one transaction every cycle while its output is
// taken, and returns one result per transaction, in order. The default FRAC_BITS of 16 gives
// Q16.16 components. The pipeline length is set by the normalize path: a 33-stage square root
// followed by a FRAC_BITS + 1 stage divider in each of four lanes; every other operation is
// delayed to the same length so results stay in order. Products use four Hamilton lanes for the
// first product and four more for the second product of a rotation. When the result at the
// output is not taken, the whole pipeline holds and in_tready drops.
module quaternion_arithmetic_unit_top
  import qau_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor
  input  logic [2:0]   in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // r_w, r_x, r_y, r_z
  output logic [1:0]   out_tuser   // saturated, zero_norm
);

  localparam int D = FRAC_BITS + 36;

  logic          en;
  logic          accept;
  op_t           op;
  quat_t         a, b, c;
  logic [31:0]   sc;
  logic          csat;
  quat_t         addr;
  logic          asat;
  side_t         side0, side_d;
  quat_t         x1 [4];
  quat_t         y1 [4];
  logic [3:0]    n1 [4];
  quat_t         y2sel, y2;
  quat_t         p1;
  logic [3:0]    p1sat;
  quat_t         p2;
  logic [3:0]    p2sat;
  quat_t         y2p [4];
  logic [128:0]  p1_d, p2_d;
  logic [31:0]   mag [4];
  logic [127:0]  mag_pk, mag_d;
  logic [63:0]   sq_r [4];
  logic [65:0]   s_r;
  logic [32:0]   root;
  logic [FRAC_BITS:0] qt [4];
  logic [31:0]   ident;

  logic [D-1:0]  vld_r, vld_nxt;
  logic          out_tvalid_r;
  quat_t         out_data_r, out_data_nxt;
  logic          out_sat_r, out_sat_nxt;
  logic          out_zn_r, out_zn_nxt;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  assign op = op_t'(in_tuser);
  assign sc = in_tdata[287:256];
  assign ident = 32'(1) << FRAC_BITS;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      a[k] = in_tdata[32*k +: 32];
      b[k] = in_tdata[128 + 32*k +: 32];
    end
  end

  // Conjugate, add and magnitudes are all formed ahead of the first register.
  always_comb begin
    logic [32:0] s33;
    logic [32:0] cl;
    c[0] = a[0];
    csat = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (a[k] == 32'h8000_0000) begin
        c[k] = 32'h7FFF_FFFF;
        csat = 1'b1;
      end else begin
        c[k] = 32'(-a[k]);
      end
    end
    asat = 1'b0;
    for (int k = 0; k < 4; k++) begin
      s33     = {a[k][31], a[k]} + {b[k][31], b[k]};
      cl      = clamp32({{33{s33[32]}}, s33});
      addr[k] = cl[31:0];
      asat    = asat | cl[32];
      mag[k]  = a[k][31] ? 32'(-a[k]) : a[k];
    end
  end

  always_comb begin
    side0.op  = op;
    side0.res = (op == OP_ADD) ? addr : c;
    side0.sat = (op == OP_ADD) ? asat :
                ((op == OP_CONJ) || (op == OP_W2B) || (op == OP_B2W)) ? csat : 1'b0;
    side0.zn  = (op == OP_NORM) && (a == '0);
    for (int k = 0; k < 4; k++) begin
      side0.neg[k] = a[k][31];
    end
  end

  // Operands of the first product lanes.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      x1[l] = '0;
      y1[l] = '0;
      n1[l] = '0;
    end
    unique case (op)
      OP_MULT, OP_W2B, OP_B2W: begin
        for (int l = 0; l < 4; l++) begin
          x1[l] = (op == OP_W2B) ? c : a;
          y1[l] = ham_perm(b, 2'(l));
          n1[l] = HAM_NEG[l];
        end
      end
      OP_DOT: begin
        x1[0] = a;
        y1[0] = b;
      end
      OP_SCALE: begin
        for (int l = 0; l < 4; l++) begin
          x1[l][0] = a[l];
          y1[l][0] = sc;
        end
      end
      OP_ADD, OP_NORM, OP_CONJ: begin
      end
    endcase
  end

  assign y2sel = (op == OP_W2B) ? a : c;

  for (genvar l = 0; l < 4; l++) begin : g_p1
    qau_prod_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .x(x1[l]), .y(y1[l]), .neg(n1[l]), .r(p1[l]), .sat(p1sat[l])
    );
  end

  qau_delay #(.W(128), .N(2)) u_y2 (.clk(clk), .en(en), .d(y2sel), .q(y2));

  for (genvar l = 0; l < 4; l++) begin : g_p2
    assign y2p[l] = ham_perm(y2, 2'(l));
    qau_prod_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk(clk), .en(en), .x(p1), .y(y2p[l]), .neg(HAM_NEG[l]), .r(p2[l]), .sat(p2sat[l])
    );
  end

  // Normalize: squares, exact sum, square root, then one divider per component.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sq_r[k] <= mag[k] * mag[k];
      end
      s_r <= {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]} + {2'b00, sq_r[3]};
    end
  end

  qau_isqrt u_isqrt (.clk(clk), .en(en), .s(s_r), .root(root));

  assign mag_pk = {mag[3], mag[2], mag[1], mag[0]};
  qau_delay #(.W(128), .N(35)) u_mag (.clk(clk), .en(en), .d(mag_pk), .q(mag_d));

  for (genvar k = 0; k < 4; k++) begin : g_div
    qau_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .en(en), .m(mag_d[32*k +: 32]), .d(root), .q(qt[k])
    );
  end

  qau_delay #(.W($bits(side_t)), .N(D)) u_side (
    .clk(clk), .en(en), .d(side0), .q(side_d)
  );
  qau_delay #(.W(129), .N(D-2)) u_p1d (
    .clk(clk), .en(en), .d({|p1sat, p1}), .q(p1_d)
  );
  qau_delay #(.W(129), .N(D-4)) u_p2d (
    .clk(clk), .en(en), .d({|p2sat, p2}), .q(p2_d)
  );

  // Merge: pick the path that served this operation.
  always_comb begin
    out_data_nxt = '0;
    out_sat_nxt  = 1'b0;
    out_zn_nxt   = 1'b0;
    unique case (side_d.op)
      OP_MULT, OP_DOT, OP_SCALE: begin
        out_data_nxt = p1_d[127:0];
        out_sat_nxt  = p1_d[128];
      end
      OP_ADD, OP_CONJ: begin
        out_data_nxt = side_d.res;
        out_sat_nxt  = side_d.sat;
      end
      OP_W2B, OP_B2W: begin
        out_data_nxt = p2_d[127:0];
        out_sat_nxt  = side_d.sat | p1_d[128] | p2_d[128];
      end
      OP_NORM: begin
        out_zn_nxt = side_d.zn;
        if (side_d.zn) begin
          out_data_nxt[0] = ident;
        end else begin
          for (int k = 0; k < 4; k++) begin
            out_data_nxt[k] = side_d.neg[k] ? 32'(-32'(qt[k])) : 32'(qt[k]);
          end
        end
      end
    endcase
  end

  assign vld_nxt = {vld_r[D-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      vld_r        <= vld_nxt;
      out_tvalid_r <= vld_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_sat_r  <= out_sat_nxt;
      out_zn_r   <= out_zn_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_zn_r, out_sat_r};

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while the output was stalled");

  a_zero_norm_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |->
      (out_tdata[31:0] == ident) && (out_tdata[127:32] == '0) && !out_tuser[0])
    else $error("zero norm result is not the identity");

endmodule

>>> test/quaternion_arithmetic_unit_top_test.sv
// Self-checking testbench of the quaternion arithmetic unit: directed and random transactions.
module quaternion_arithmetic_unit_top_test
  import qau_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int LATENCY = FRAC + 37;

  typedef struct {
    logic [31:0] w, x, y, z;
    logic sat, zn;
  } qres_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [287:0] in_tdata;
  logic [2:0] in_tuser;
  logic [127:0] out_tdata;
  logic [1:0] out_tuser;

  bit calm;          // no random idling on either side
  bit hold_off;      // receiver held off by its own process
  int long_hold;

  quaternion_arithmetic_unit_top #(.FRAC_BITS(FRAC)) i_dut (.*);

  // Arithmetic that mirrors the block's fixed-point behavior.
  function automatic longint prod_q(logic signed [31:0] p, logic signed [31:0] q);
    longint t;
    t = longint'(p) * longint'(q);
    return t >>> FRAC;
  endfunction

  function automatic logic signed [31:0] sat32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  typedef logic signed [31:0] q4_t [4];

  function automatic void hamilton(q4_t a, q4_t b, ref q4_t r, ref bit sat);
    r[0] = sat32(prod_q(a[0], b[0]) - prod_q(a[1], b[1]) - prod_q(a[2], b[2])
                 - prod_q(a[3], b[3]), sat);
    r[1] = sat32(prod_q(a[0], b[1]) + prod_q(a[1], b[0]) + prod_q(a[2], b[3])
                 - prod_q(a[3], b[2]), sat);
    r[2] = sat32(prod_q(a[0], b[2]) - prod_q(a[1], b[3]) + prod_q(a[2], b[0])
                 + prod_q(a[3], b[1]), sat);
    r[3] = sat32(prod_q(a[0], b[3]) + prod_q(a[1], b[2]) - prod_q(a[2], b[1])
                 + prod_q(a[3], b[0]), sat);
  endfunction

  function automatic void conjugate(q4_t a, ref q4_t r, ref bit sat);
    r[0] = a[0];
    for (int i = 1; i < 4; i++) r[i] = sat32(-longint'(a[i]), sat);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [64:0] s);
    logic [64:0] res, bitv;
    res = 0;
    bitv = 65'd1 << 64;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[63:0];
  endfunction

  function automatic qres_t compute_quat(op_t op, logic [287:0] d);
    q4_t a, b, r, t, c;
    logic signed [31:0] sc;
    bit sat, zn;
    logic [64:0] ssum;
    logic [63:0] nrm, m;
    logic [95:0] quo;
    qres_t e;
    sat = 0;
    zn = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = d[32*i +: 32];
      b[i] = d[128 + 32*i +: 32];
    end
    sc = d[256 +: 32];
    case (op)
      OP_MULT: hamilton(a, b, r, sat);
      OP_DOT: begin
        r[0] = sat32(prod_q(a[0], b[0]) + prod_q(a[1], b[1]) + prod_q(a[2], b[2])
                     + prod_q(a[3], b[3]), sat);
        r[1] = 0;
        r[2] = 0;
        r[3] = 0;
      end
      OP_ADD: for (int i = 0; i < 4; i++) r[i] = sat32(longint'(a[i]) + longint'(b[i]), sat);
      OP_SCALE: for (int i = 0; i < 4; i++) r[i] = sat32(prod_q(a[i], sc), sat);
      OP_NORM: begin
        ssum = 0;
        for (int i = 0; i < 4; i++) begin
          m = a[i] < 0 ? 64'(-longint'(a[i])) : 64'(a[i]);
          ssum += m * m;
        end
        if (ssum == 0) begin
          r[0] = 32'sd1 <<< FRAC;
          r[1] = 0;
          r[2] = 0;
          r[3] = 0;
          zn = 1;
        end else begin
          nrm = int_sqrt(ssum);
          for (int i = 0; i < 4; i++) begin
            m = a[i] < 0 ? 64'(-longint'(a[i])) : 64'(a[i]);
            quo = {32'd0, m} << FRAC;
            quo = quo / nrm;
            r[i] = sat32(a[i] < 0 ? -longint'(quo) : longint'(quo), sat);
          end
        end
      end
      OP_CONJ: conjugate(a, r, sat);
      OP_W2B: begin
        conjugate(a, c, sat);
        hamilton(c, b, t, sat);
        hamilton(t, a, r, sat);
      end
      default: begin
        conjugate(a, c, sat);
        hamilton(a, b, t, sat);
        hamilton(t, c, r, sat);
      end
    endcase
    e.w = r[0];
    e.x = r[1];
    e.y = r[2];
    e.z = r[3];
    e.sat = sat;
    e.zn = zn;
    return e;
  endfunction

  class quat_scoreboard;
    qres_t pending_results[$];
    int mismatches;

    function void note_input(op_t op, logic [287:0] d);
      pending_results.push_back(compute_quat(op, d));
    endfunction

    function void check_result(logic [127:0] d, logic [1:0] u);
      qres_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h flags %b", d, u);
        return;
      end
      e = pending_results.pop_front();
      if (d !== {e.z, e.y, e.x, e.w} || u !== {e.zn, e.sat}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h %h %h %h sat %b zn %b, got %h flags %b",
                   e.w, e.x, e.y, e.z, e.sat, e.zn, d, u);
      end
    endfunction
  endclass

  quat_scoreboard sb = new();

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when asked.
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_off && long_hold > 0) begin
        long_hold--;
        out_tready <= 0;
      end else begin
        out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 16);
      end
    end
  end

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      3: return 32'($signed($urandom_range(2048)) - 1024);
      default: return $urandom;
    endcase
  endfunction

  // Leaves in_tvalid high after the handshake; the caller drops it when it stops sending.
  task automatic send_item(op_t op, logic [287:0] d);
    while (!calm && $urandom_range(99) < 16) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, d);
  endtask

  task automatic send_random(int n);
    logic [287:0] d;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 9; i++) d[32*i +: 32] = rand_comp();
      if ($urandom_range(9) == 0)
        for (int i = 0; i < 4; i++) d[32*i +: 32] = $urandom_range(1) ? 32'h8000_0000 : 32'h0;
      send_item(op_t'($urandom_range(7)), d);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 0;
    while (sb.pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    logic [287:0] d;
    logic [31:0] one;
    one = 32'h0001_0000;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = OP_MULT;
    calm = 0;
    hold_off = 0;
    long_hold = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: every operation on identity, extremes, zero and all-minimum normalize.
    for (int o = 0; o < 8; o++) begin
      d = '0;
      d[0 +: 32] = one;
      d[128 +: 32] = 32'h0002_0000;
      d[160 +: 32] = 32'hFFFF_8000;
      d[256 +: 32] = 32'hFFFE_0000;
      send_item(op_t'(o), d);
      send_item(op_t'(o), {9{32'h7FFF_FFFF}});
      send_item(op_t'(o), {9{32'h8000_0000}});
    end
    send_item(OP_NORM, '0);
    send_item(OP_NORM, {160'd0, 32'h0000_0003, 96'd0});
    send_item(OP_CONJ, {192'd0, 32'h8000_0000, 64'd0});
    drain();

    send_random(300);
    // Stop sending until every result has come back.
    drain();

    // Hold the receiver off so that the pipeline fills and in_tready drops.
    long_hold = 200;
    hold_off = 1;
    send_random(150);
    hold_off = 0;

    calm = 1;
    send_random(150);
    calm = 0;
    send_random(150);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
